@@ hdl/union_find_maze_wall_remover_assert.svh @@
// Assertion macros shared by the maze wall remover RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef UNION_FIND_MAZE_WALL_REMOVER_ASSERT_SVH
`define UNION_FIND_MAZE_WALL_REMOVER_ASSERT_SVH

// Same-cycle implication.
`define UFMW_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("ufmw assertion failed (same-cycle implication)");

// Next-cycle implication.
`define UFMW_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("ufmw assertion failed (next-cycle implication)");

`endif

@@ hdl/ufmw_pkg.sv @@
// Shared types and constants for the union-find maze wall remover.
// No dependencies; imported by the controller, datapath and top level.
package ufmw_pkg;

  localparam int CELL_W        = 10;
  localparam int DIM_W         = 6;
  localparam int ROW_W         = 5;
  localparam int COL_W         = 5;
  localparam int DIR_W         = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int MAX_CELLS_DEF = 1024;

  localparam logic [DIM_W-1:0] DIM_MIN   = 6'd2;
  localparam logic [DIM_W-1:0] DIM_MAX   = 6'd32;
  localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

  typedef enum logic [DIR_W-1:0] {
    DIR_WEST  = 2'd0,
    DIR_SOUTH = 2'd1,
    DIR_EAST  = 2'd2,
    DIR_NORTH = 2'd3
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1
  } cfg_reg_t;

  // Datapath operation issued by the controller each cycle.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_PREP,
    OP_WALK_A,
    OP_WALK_B
  } dp_op_t;

  // Status returned by the datapath.
  typedef struct packed {
    logic restart;   // grid register write, maze restarts
    logic skip;      // maze done, cell off grid or index past store: no walk
    logic hit;       // current node is its own parent
    logic clr_last;  // clearing pass at last entry
  } dp_status_t;

endpackage

@@ hdl/ufmw_datapath.sv @@
// Datapath: grid registers, parent store memory, union counter, result registers.
// Depends on ufmw_pkg and union_find_maze_wall_remover_assert.svh.
`include "union_find_maze_wall_remover_assert.svh"

module ufmw_datapath import ufmw_pkg::*; #(
  parameter int MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic [ROW_W-1:0]     in_cell_row,
  input  logic [COL_W-1:0]     in_cell_col,
  input  logic [DIR_W-1:0]     in_dir_code,
  input  dp_op_t               op,
  output dp_status_t           status,
  output logic                 out_merged,
  output logic [CELL_W-1:0]    out_wall_cell,
  output logic                 out_wall_is_south,
  output logic                 out_finished,
  output logic                 out_bad_cell
);

  localparam int IDX_W = $clog2(MAX_CELLS);
  localparam logic [16:0]      MAX_IDX  = 17'(MAX_CELLS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CELLS - 1);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v < DIM_MIN) begin
      return DIM_MIN;
    end else if (v > DIM_MAX) begin
      return DIM_MAX;
    end
    return v;
  endfunction

  // config and control registers
  logic [DIM_W-1:0]  rows_r, cols_r;
  logic [CELL_W-1:0] cells_m1_r, cells_m1_nxt;
  logic [CELL_W-1:0] union_cnt_r;
  logic [IDX_W-1:0]  clr_r;
  logic              merged_r, bad_r;

  // item payload registers
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  dir_t              dir_r;
  logic [IDX_W-1:0]  nb_r, cur_r, ra_r;
  logic [CELL_W-1:0] wall_r;
  logic              south_r;

  // parent store
  logic [IDX_W-1:0]  store_mem [MAX_CELLS];
  logic [IDX_W-1:0]  rd_data_r;
  logic [IDX_W-1:0]  rd_addr, mem_wa, mem_wd;
  logic              mem_we;

  logic [DIM_W-1:0]  rows_c, cols_c;
  logic [11:0]       cells_prod;
  logic [10:0]       cell_lin, nb_lin, wall_lin;
  logic              wall_south, off_grid, idx_bad, bad_now, done;
  logic              restart, hit, do_union;

  assign rows_c       = clamp_dim(rows_r);
  assign cols_c       = clamp_dim(cols_r);
  assign cells_prod   = 12'(rows_c) * 12'(cols_c);
  assign cells_m1_nxt = CELL_W'(cells_prod - 12'd1);
  assign done         = union_cnt_r >= cells_m1_r;

  assign restart  = cfg_valid && (cfg_index == REG_ROWS || cfg_index == REG_COLS);
  assign hit      = rd_data_r == cur_r;
  assign do_union = (op == OP_WALK_B) && hit && (cur_r != ra_r);

  // neighbor selection with reflection off the grid edge
  always_comb begin
    cell_lin   = 11'(row_r) * 11'(cols_c) + 11'(col_r);
    nb_lin     = cell_lin;
    wall_lin   = cell_lin;
    wall_south = 1'b0;
    case (dir_r)
      DIR_WEST: begin
        if (col_r != '0) begin
          nb_lin   = cell_lin - 11'd1;
          wall_lin = nb_lin;
        end else begin
          nb_lin   = cell_lin + 11'd1;
        end
      end
      DIR_SOUTH: begin
        wall_south = 1'b1;
        if ({1'b0, row_r} < rows_c - 6'd1) begin
          nb_lin   = cell_lin + 11'(cols_c);
        end else begin
          nb_lin   = cell_lin - 11'(cols_c);
          wall_lin = nb_lin;
        end
      end
      DIR_EAST: begin
        if ({1'b0, col_r} != cols_c - 6'd1) begin
          nb_lin   = cell_lin + 11'd1;
        end else begin
          nb_lin   = cell_lin - 11'd1;
          wall_lin = nb_lin;
        end
      end
      DIR_NORTH: begin
        wall_south = 1'b1;
        if (row_r != '0) begin
          nb_lin   = cell_lin - 11'(cols_c);
          wall_lin = nb_lin;
        end else begin
          nb_lin   = cell_lin + 11'(cols_c);
        end
      end
      default: begin
        nb_lin = cell_lin;
      end
    endcase
  end

  assign off_grid = ({1'b0, row_r} >= rows_c) || ({1'b0, col_r} >= cols_c);
  assign idx_bad  = ({6'b0, cell_lin} >= MAX_IDX) || ({6'b0, nb_lin} >= MAX_IDX);
  assign bad_now  = off_grid || idx_bad;

  // memory port control
  always_comb begin
    rd_addr = cur_r;
    mem_we  = 1'b0;
    mem_wa  = cur_r;
    mem_wd  = ra_r;
    case (op)
      OP_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = clr_r;
      end
      OP_PREP: begin
        rd_addr = IDX_W'(cell_lin);
      end
      OP_WALK_A: begin
        rd_addr = hit ? nb_r : rd_data_r;
      end
      OP_WALK_B: begin
        rd_addr = rd_data_r;
        mem_we  = do_union;
      end
      default: begin
        rd_addr = cur_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= DIM_RESET;
      cols_r      <= DIM_RESET;
      cells_m1_r  <= CELL_W'(MAX_CELLS_DEF - 1);
      union_cnt_r <= '0;
      clr_r       <= '0;
      merged_r    <= 1'b0;
      bad_r       <= 1'b0;
    end else begin
      cells_m1_r <= cells_m1_nxt;
      if (cfg_valid && cfg_index == REG_ROWS) begin
        rows_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == REG_COLS) begin
        cols_r <= cfg_data;
      end
      if (restart) begin
        union_cnt_r <= '0;
        clr_r       <= '0;
      end else begin
        if (op == OP_CLEAR) begin
          clr_r <= clr_r + 1'b1;
        end
        if (do_union) begin
          union_cnt_r <= union_cnt_r + 1'b1;
        end
      end
      if (op == OP_PREP) begin
        merged_r <= 1'b0;
        bad_r    <= !done && bad_now;
      end else if (do_union) begin
        merged_r <= 1'b1;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        row_r <= in_cell_row;
        col_r <= in_cell_col;
        dir_r <= dir_t'(in_dir_code);
      end
      OP_PREP: begin
        nb_r    <= IDX_W'(nb_lin);
        cur_r   <= IDX_W'(cell_lin);
        wall_r  <= CELL_W'(wall_lin);
        south_r <= wall_south;
      end
      OP_WALK_A: begin
        if (hit) begin
          ra_r  <= cur_r;
          cur_r <= nb_r;
        end else begin
          cur_r <= rd_data_r;
        end
      end
      OP_WALK_B: begin
        if (!hit) begin
          cur_r <= rd_data_r;
        end
      end
      default: begin
        cur_r <= cur_r;
      end
    endcase
  end

  assign status.restart  = restart;
  assign status.skip     = done || bad_now;
  assign status.hit      = hit;
  assign status.clr_last = clr_r == LAST_IDX;

  assign out_merged        = merged_r;
  assign out_wall_cell     = merged_r ? wall_r : '0;
  assign out_wall_is_south = merged_r && south_r;
  assign out_finished      = done;
  assign out_bad_cell      = bad_r;

  `UFMW_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, union_cnt_r <= cells_m1_r)
  `UFMW_ASSERT_IMPL(a_merge_not_bad, clk, rst_n, merged_r, !bad_r)
  `UFMW_ASSERT_NEXT(a_union_counts, clk, rst_n, do_union && !restart, union_cnt_r == CELL_W'($past(union_cnt_r) + 1'b1))

endmodule

@@ hdl/ufmw_ctrl.sv @@
// Controller state machine: sequences clearing, root walks and the result strobe.
// Depends on ufmw_pkg and union_find_maze_wall_remover_assert.svh.
`include "union_find_maze_wall_remover_assert.svh"

module ufmw_ctrl import ufmw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t status,
  output dp_op_t     op,
  output logic       busy,
  output logic       out_valid
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_WALK_A,
    S_WALK_B,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, out_valid_r;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op        = OP_LOAD;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        op        = OP_PREP;
        state_nxt = status.skip ? S_OUT : S_WALK_A;
      end
      S_WALK_A: begin
        op = OP_WALK_A;
        if (status.hit) begin
          state_nxt = S_WALK_B;
        end
      end
      S_WALK_B: begin
        op = OP_WALK_B;
        if (status.hit) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (status.restart) begin
      state_nxt = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= state_nxt != S_IDLE;
      out_valid_r <= state_nxt == S_OUT;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

  `UFMW_ASSERT_IMPL(a_strobe_while_busy, clk, rst_n, out_valid_r, busy_r)
  `UFMW_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid_r, !out_valid_r)
  `UFMW_ASSERT_NEXT(a_accept_no_strobe, clk, rst_n, start && !busy_r, !out_valid_r)
  `UFMW_ASSERT_NEXT(a_restart_clears, clk, rst_n, status.restart, state_r == S_CLEAR)

endmodule

@@ hdl/union_find_maze_wall_remover.sv @@
// After the accept, PREP resolves the item, WALK_A and WALK_B take La and Lb parent hops
//   from the cell and its neighbor to their roots, and OUT gives the strobe; an off-grid
//   or done item skips the walks. A new item waits for the strobe; one hop per cycle.
// Reset, and every grid register write, runs a clearing pass over all MAX_CELLS entries of
//   the parent store with busy high; config writes are always taken.
// Results are one-cycle strobes on out_valid; the receiver cannot stall.
//
// Top level of the union-find maze wall remover. Depends on ufmw_pkg, ufmw_ctrl
// and ufmw_datapath.
module union_find_maze_wall_remover import ufmw_pkg::*; #(
  parameter int MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // command channel: a transaction is start high while busy is low
  input  logic                 start,
  output logic                 busy,
  input  logic [ROW_W-1:0]     in_cell_row,
  input  logic [COL_W-1:0]     in_cell_col,
  input  logic [DIR_W-1:0]     in_dir_code,
  // register write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  // result strobe
  output logic                 out_valid,
  output logic                 out_merged,
  output logic [CELL_W-1:0]    out_wall_cell,
  output logic                 out_wall_is_south,
  output logic                 out_finished,
  output logic                 out_bad_cell
);

  dp_op_t     op;
  dp_status_t status;

  // Register writes never stall; software writes only while the block is idle.
  // A write to either grid register restarts the maze (clearing pass).
  assign cfg_ready = 1'b1;

  // Controller walks: CLEAR -> IDLE -> PREP -> WALK_A -> WALK_B -> OUT (PREP -> OUT on a skip).
  // PREP resolves the neighbor (with edge reflection) and the off-grid check;
  // the walks chase parent pointers one hop per cycle; WALK_B links root B to
  // root A when they differ.
  ufmw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .op        (op),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Datapath holds the parent store, the union count and the result registers.
  ufmw_datapath #(
    .MAX_CELLS (MAX_CELLS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_cell_row       (in_cell_row),
    .in_cell_col       (in_cell_col),
    .in_dir_code       (in_dir_code),
    .op                (op),
    .status            (status),
    .out_merged        (out_merged),
    .out_wall_cell     (out_wall_cell),
    .out_wall_is_south (out_wall_is_south),
    .out_finished      (out_finished),
    .out_bad_cell      (out_bad_cell)
  );

endmodule

@@ test/union_find_maze_wall_remover_test.sv @@
// Self-checking testbench for the union-find maze wall remover.
// Depends on ufmw_pkg and the union_find_maze_wall_remover RTL; needs nothing else.
module union_find_maze_wall_remover_test;
  import ufmw_pkg::*;

  localparam int    CLK_HALF     = 10;
  localparam int    ITEM_TARGET  = 1850;
  localparam int    PHASE_BUDGET = 400;  // item cap per maze, big grids rarely finish
  localparam int    SETTLE_WAIT  = 8;    // extra wait in settle() after the last owed result
  localparam int    TAIL_WAIT    = 40;
  localparam longint LIMIT_TIME  = 64'd800_000_000;

  // Index values past the two grid registers: writes to them do nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic              merged;
    logic [CELL_W-1:0] wall_cell;
    logic              wall_is_south;
    logic              finished;
    logic              bad_cell;
  } wall_result_t;

  // Tracks the maze: its own parent store, join count and grid registers, and the
  // queue of wall reports still owed by the block.
  class wall_tracker;
    int unsigned      parent [MAX_CELLS_DEF];
    int unsigned      joins;
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    wall_result_t     pending_walls [$];
    int               errors;
    int               results_seen;
    int               merges_seen;
    int               bad_seen;

    function new();
      rows_reg = DIM_RESET;
      cols_reg = DIM_RESET;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < MAX_CELLS_DEF; i++) parent[i] = i;
      joins = 0;
    endfunction

    function int unsigned clamp_dim(logic [DIM_W-1:0] v);
      if (v < DIM_MIN) return 32'(DIM_MIN);
      if (v > DIM_MAX) return 32'(DIM_MAX);
      return 32'(v);
    endfunction

    function int unsigned rows_used();
      return clamp_dim(rows_reg);
    endfunction

    function int unsigned cols_used();
      return clamp_dim(cols_reg);
    endfunction

    function bit maze_done();
      return joins >= rows_used() * cols_used() - 1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      if (idx == REG_ROWS) begin
        rows_reg = data;
        restart();
      end else if (idx == REG_COLS) begin
        cols_reg = data;
        restart();
      end
    endfunction

    function int unsigned root_of(int unsigned x);
      while (parent[x] != x) x = parent[x];
      return x;
    endfunction

    function void note_item(logic [ROW_W-1:0] r, logic [COL_W-1:0] c, dir_t d);
      wall_result_t want;
      int unsigned  rows, cols, row_u, col_u, nr, nc, cell_idx, nb_idx, ra, rb;
      dir_t         dd;
      want  = '0;
      rows  = rows_used();
      cols  = cols_used();
      row_u = 32'(r);
      col_u = 32'(c);
      nr    = row_u;
      nc    = col_u;
      dd    = d;
      if (!maze_done()) begin
        if (row_u >= rows || col_u >= cols) begin
          want.bad_cell = 1'b1;
        end else begin
          // off-grid directions bounce to the opposite neighbor
          case (dd)
            DIR_WEST: begin
              if (col_u != 0) nc = col_u - 1;
              else begin
                nc = col_u + 1;
                dd = DIR_EAST;
              end
            end
            DIR_SOUTH: begin
              if (row_u < rows - 1) nr = row_u + 1;
              else begin
                nr = row_u - 1;
                dd = DIR_NORTH;
              end
            end
            DIR_EAST: begin
              if (col_u != cols - 1) nc = col_u + 1;
              else begin
                nc = col_u - 1;
                dd = DIR_WEST;
              end
            end
            default: begin
              if (row_u > 0) nr = row_u - 1;
              else begin
                nr = row_u + 1;
                dd = DIR_SOUTH;
              end
            end
          endcase
          cell_idx = row_u * cols + col_u;
          nb_idx   = nr * cols + nc;
          if (cell_idx >= MAX_CELLS_DEF || nb_idx >= MAX_CELLS_DEF) begin
            want.bad_cell = 1'b1;
          end else begin
            ra = root_of(cell_idx);
            rb = root_of(nb_idx);
            if (ra != rb) begin
              parent[rb]  = ra;
              joins       = (joins + 1) & 32'h3FF;
              want.merged = 1'b1;
              // the wall always belongs to the lower-indexed cell
              case (dd)
                DIR_WEST: begin
                  want.wall_cell     = CELL_W'(nb_idx);
                  want.wall_is_south = 1'b0;
                end
                DIR_SOUTH: begin
                  want.wall_cell     = CELL_W'(cell_idx);
                  want.wall_is_south = 1'b1;
                end
                DIR_EAST: begin
                  want.wall_cell     = CELL_W'(cell_idx);
                  want.wall_is_south = 1'b0;
                end
                default: begin
                  want.wall_cell     = CELL_W'(nb_idx);
                  want.wall_is_south = 1'b1;
                end
              endcase
            end
          end
        end
      end
      want.finished = maze_done();
      pending_walls.push_back(want);
    endfunction

    task report(string msg);
      if (errors < 100) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(wall_result_t got);
      wall_result_t want;
      results_seen++;
      if (got.merged)   merges_seen++;
      if (got.bad_cell) bad_seen++;
      if (pending_walls.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_walls.pop_front();
        if (got !== want)
          report($sformatf({"result %0d: want merged=%0d wall=%0d south=%0d fin=%0d bad=%0d,",
                            " got merged=%0d wall=%0d south=%0d fin=%0d bad=%0d"},
                           results_seen, want.merged, want.wall_cell, want.wall_is_south,
                           want.finished, want.bad_cell, got.merged, got.wall_cell,
                           got.wall_is_south, got.finished, got.bad_cell));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [ROW_W-1:0]     in_cell_row = '0;
  logic [COL_W-1:0]     in_cell_col = '0;
  logic [DIR_W-1:0]     in_dir_code = '0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 out_valid;
  logic                 out_merged;
  logic [CELL_W-1:0]    out_wall_cell;
  logic                 out_wall_is_south;
  logic                 out_finished;
  logic                 out_bad_cell;

  wall_tracker tracker;
  int          items_run;    // random items sent while the maze was unfinished
  int          mazes_done;
  int          reg_writes;
  bit          allow_gaps;

  union_find_maze_wall_remover dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cell_row       (in_cell_row),
    .in_cell_col       (in_cell_col),
    .in_dir_code       (in_dir_code),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_merged        (out_merged),
    .out_wall_cell     (out_wall_cell),
    .out_wall_is_south (out_wall_is_south),
    .out_finished      (out_finished),
    .out_bad_cell      (out_bad_cell)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Result strobes cannot be held off, so every pulse is checked at its edge.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      tracker.check_result('{out_merged, out_wall_cell, out_wall_is_south,
                             out_finished, out_bad_cell});
  end

  // Drop start and scramble the command fields; they must be ignored while start is low.
  task automatic drop_start();
    @(negedge clk);
    start       = 1'b0;
    in_cell_row = ROW_W'($urandom);
    in_cell_col = COL_W'($urandom);
    in_dir_code = DIR_W'($urandom);
  endtask

  task automatic sender_pause(int unsigned cycles);
    drop_start();
    repeat (cycles - 1) @(negedge clk);
  endtask

  // One command transaction. start is left high so the next item can follow
  // back to back; whoever comes next lowers it if needed.
  task automatic send_item(logic [ROW_W-1:0] r, logic [COL_W-1:0] c, dir_t d);
    @(negedge clk);
    start       = 1'b1;
    in_cell_row = r;
    in_cell_col = c;
    in_dir_code = d;
    do @(posedge clk); while (busy);
    tracker.note_item(r, c, d);
  endtask

  // Block goes quiet: no result owed, tail latency passed, clearing pass over.
  task automatic settle();
    drop_start();
    while (tracker.pending_walls.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    settle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly a cell inside the grid; now and then anything the fields allow.
  task automatic random_item();
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    if ($urandom_range(0, 99) < 85) begin
      r = ROW_W'($urandom_range(0, tracker.rows_used() - 1));
      c = COL_W'($urandom_range(0, tracker.cols_used() - 1));
    end else begin
      r = ROW_W'($urandom_range(0, 31));
      c = COL_W'($urandom_range(0, 31));
    end
    send_item(r, c, dir_t'($urandom_range(0, 3)));
  endtask

  initial begin
    logic [DIM_W-1:0] new_rows, new_cols;
    int unsigned      sel, n, spare_at;
    tracker    = new();
    items_run  = 0;
    mazes_done = 0;
    reg_writes = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed: full 32x32 grid after reset ---
    send_item(0, 0, DIR_WEST);      // west edge bounces east
    send_item(0, 0, DIR_NORTH);     // north edge bounces south
    send_item(0, 1, DIR_WEST);      // already joined
    send_item(31, 31, DIR_EAST);    // far corner bounces west
    send_item(31, 31, DIR_SOUTH);   // far corner bounces north
    send_item(0, 31, DIR_NORTH);
    send_item(31, 0, DIR_WEST);
    send_item(15, 16, DIR_WEST);
    send_item(15, 16, DIR_SOUTH);
    send_item(15, 16, DIR_EAST);
    send_item(15, 16, DIR_NORTH);
    send_item(0, 0, DIR_EAST);      // same set again
    write_reg(REG_SPARE_A, 6'd63);  // unused index: maze must survive
    send_item(0, 1, DIR_WEST);

    // --- directed: minimal 2x2 grid via clamped register values ---
    write_reg(REG_ROWS, 6'd0);
    write_reg(REG_COLS, 6'd1);
    send_item(2, 0, DIR_SOUTH);     // row off grid
    send_item(0, 2, DIR_EAST);      // column off grid
    send_item(0, 0, DIR_EAST);
    send_item(1, 1, DIR_NORTH);
    send_item(1, 0, DIR_EAST);      // third join completes the maze
    send_item(1, 1, DIR_WEST);      // ignored, finished
    send_item(31, 31, DIR_NORTH);   // finished wins over off grid
    mazes_done++;

    // --- directed: clamping from above, then a narrow grid ---
    write_reg(REG_ROWS, 6'd63);
    write_reg(REG_COLS, 6'd33);
    send_item(31, 31, DIR_WEST);
    send_item(31, 0, DIR_SOUTH);
    write_reg(REG_SPARE_B, 6'd0);
    write_reg(REG_COLS, 6'd3);
    send_item(1, 2, DIR_EAST);

    // --- random mazes: mostly small grids so they run to completion ---
    while (items_run < ITEM_TARGET) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        new_rows = DIM_W'($urandom);
        new_cols = DIM_W'($urandom);
      end else if (sel == 1) begin
        new_rows = $urandom_range(0, 1) ? 6'd63 : DIM_W'($urandom_range(0, 1));
        new_cols = $urandom_range(0, 1) ? 6'd32 : DIM_W'($urandom_range(0, 2));
      end else begin
        new_rows = DIM_W'($urandom_range(2, 8));
        new_cols = DIM_W'($urandom_range(2, 8));
      end
      write_reg(REG_ROWS, new_rows);
      write_reg(REG_COLS, new_cols);
      spare_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : 0;
      n = 0;
      while (n < PHASE_BUDGET && !tracker.maze_done() && items_run < ITEM_TARGET) begin
        if (n == spare_at && n != 0)
          write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, DIM_W'($urandom));
        allow_gaps = items_run < ITEM_TARGET * 85 / 100;
        if (allow_gaps && $urandom_range(0, 3) == 0)
          sender_pause($urandom_range(1, 8));
        random_item();
        items_run++;
        n++;
      end
      if (tracker.maze_done()) begin
        mazes_done++;
        // a finished maze must ignore whatever comes next
        repeat ($urandom_range(1, 2)) random_item();
      end
    end

    drop_start();
    while (tracker.pending_walls.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Run covered %0d random items over %0d completed mazes and %0d register writes;",
             items_run, mazes_done, reg_writes);
    $display("%0d results checked, %0d walls removed, %0d off-grid cells flagged.",
             tracker.results_seen, tracker.merges_seen, tracker.bad_seen);
    if (tracker.errors == 0) begin
      $display("union_find_maze_wall_remover_test passed");
    end else begin
      $display("union_find_maze_wall_remover_test failed");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #(LIMIT_TIME);
    $display("union_find_maze_wall_remover_test failed");
    $finish;
  end

endmodule
